FILE: rtl/core/eeg_serial_packet_parser_assert.svh
// Assertion macros shared by the EEG serial packet parser modules.
`ifndef EEG_SERIAL_PACKET_PARSER_ASSERT_SVH
`define EEG_SERIAL_PACKET_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define ESP_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("eeg parser check failed");
// Checks that a condition in one cycle leads to another in the next cycle.
`define ESP_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eeg parser sequence check failed");
`else
`define ESP_CHECK(label, clk, rst, prop)
`define ESP_CHECK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/esp_pkg.sv
// Types and constants of the EEG serial packet parser.
package esp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    ST_HUNT  = 8'b0000_0001,
    ST_AA1   = 8'b0000_0010,
    ST_AA2   = 8'b0000_0100,
    ST_R04   = 8'b0000_1000,
    ST_R80   = 8'b0001_0000,
    ST_L20   = 8'b0010_0000,
    ST_RBODY = 8'b0100_0000,
    ST_LBODY = 8'b1000_0000
  } esp_state_t;

  typedef logic [5:0] esp_index_t;
  typedef logic [1:0] esp_kind_t;

  localparam esp_kind_t KIND_RAW_OK     = 2'd0;
  localparam esp_kind_t KIND_RAW_FAIL   = 2'd1;
  localparam esp_kind_t KIND_LARGE_OK   = 2'd2;
  localparam esp_kind_t KIND_LARGE_FAIL = 2'd3;

  // Header bytes and body marker bytes.
  localparam logic [7:0] SYNC_BYTE      = 8'hAA;
  localparam logic [7:0] RAW_LEN_BYTE   = 8'h04;
  localparam logic [7:0] RAW_CODE_BYTE  = 8'h80;
  localparam logic [7:0] RAW_SIZE_BYTE  = 8'h02;
  localparam logic [7:0] LARGE_LEN_BYTE = 8'h20;
  localparam logic [7:0] LARGE_CODE     = 8'h02;
  localparam logic [7:0] ATT_MARK_BYTE  = 8'h04;
  localparam logic [7:0] MED_MARK_BYTE  = 8'h05;

  // Packet offsets.
  localparam esp_index_t RAW_HIGH_IDX = 6'd5;
  localparam esp_index_t RAW_LOW_IDX  = 6'd6;
  localparam esp_index_t RAW_CHK_IDX  = 6'd7;
  localparam esp_index_t LARGE_FIRST  = 6'd4;
  localparam esp_index_t ATT_MARK_IDX = 6'd31;
  localparam esp_index_t ATT_IDX      = 6'd32;
  localparam esp_index_t MED_MARK_IDX = 6'd33;
  localparam esp_index_t MED_IDX      = 6'd34;
  localparam esp_index_t LARGE_LAST   = 6'd35;

  typedef struct packed {
    esp_kind_t   kind;
    logic [15:0] sample;
    logic [7:0]  attention;
    logic [7:0]  meditation;
  } esp_result_t;

endpackage

FILE: rtl/core/esp_fsm.sv
// Header hunting state machine and packet body decoder.
`include "eeg_serial_packet_parser_assert.svh"
module esp_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data,
  output logic                 emit,
  output esp_pkg::esp_result_t result
);

  esp_pkg::esp_state_t state, state_next;
  esp_pkg::esp_index_t body_index, body_index_next;
  logic [7:0] sample_high, sample_high_next;
  logic [7:0] sample_low, sample_low_next;
  logic [7:0] attention_hold, attention_hold_next;
  logic [7:0] meditation_hold, meditation_hold_next;
  logic       markers_ok, markers_ok_next;
  logic [7:0] sum;
  logic       fits;
  esp_pkg::esp_state_t fallback;

  // Checksum is the inverted low byte of code + size + both sample bytes.
  assign sum = esp_pkg::RAW_CODE_BYTE + esp_pkg::RAW_SIZE_BYTE + sample_high + sample_low;
  assign fits = (~sum == data);
  assign fallback = (data == esp_pkg::SYNC_BYTE) ? esp_pkg::ST_AA1 : esp_pkg::ST_HUNT;

  // The emit flag marks a word that ends a packet; it depends on the state and the body index only.
  always_comb begin
    state_next           = state;
    body_index_next      = body_index;
    sample_high_next     = sample_high;
    sample_low_next      = sample_low;
    attention_hold_next  = attention_hold;
    meditation_hold_next = meditation_hold;
    markers_ok_next      = markers_ok;
    emit                 = 1'b0;
    result               = '0;
    case (state)
      esp_pkg::ST_AA1: begin
        state_next = (data == esp_pkg::SYNC_BYTE) ? esp_pkg::ST_AA2 : esp_pkg::ST_HUNT;
      end
      esp_pkg::ST_AA2: begin
        if (data == esp_pkg::RAW_LEN_BYTE) begin
          state_next = esp_pkg::ST_R04;
        end else if (data == esp_pkg::LARGE_LEN_BYTE) begin
          state_next = esp_pkg::ST_L20;
        end else if (data == esp_pkg::SYNC_BYTE) begin
          state_next = esp_pkg::ST_AA2;
        end else begin
          state_next = esp_pkg::ST_HUNT;
        end
      end
      esp_pkg::ST_R04: begin
        state_next = (data == esp_pkg::RAW_CODE_BYTE) ? esp_pkg::ST_R80 : fallback;
      end
      esp_pkg::ST_R80: begin
        if (data == esp_pkg::RAW_SIZE_BYTE) begin
          state_next      = esp_pkg::ST_RBODY;
          body_index_next = esp_pkg::RAW_HIGH_IDX;
        end else begin
          state_next = fallback;
        end
      end
      esp_pkg::ST_L20: begin
        if (data == esp_pkg::LARGE_CODE) begin
          state_next      = esp_pkg::ST_LBODY;
          body_index_next = esp_pkg::LARGE_FIRST;
          markers_ok_next = 1'b1;
        end else begin
          state_next = fallback;
        end
      end
      esp_pkg::ST_RBODY: begin
        if (body_index == esp_pkg::RAW_HIGH_IDX) begin
          sample_high_next = data;
          body_index_next  = esp_pkg::RAW_LOW_IDX;
        end else if (body_index == esp_pkg::RAW_LOW_IDX) begin
          sample_low_next = data;
          body_index_next = esp_pkg::RAW_CHK_IDX;
        end else begin
          emit        = 1'b1;
          result.kind = fits ? esp_pkg::KIND_RAW_OK : esp_pkg::KIND_RAW_FAIL;
          result.sample = fits ? {sample_high, sample_low} : 16'd0;
          state_next      = esp_pkg::ST_HUNT;
          body_index_next = '0;
        end
      end
      esp_pkg::ST_LBODY: begin
        if (body_index == esp_pkg::ATT_MARK_IDX && data != esp_pkg::ATT_MARK_BYTE) begin
          markers_ok_next = 1'b0;
        end else if (body_index == esp_pkg::ATT_IDX) begin
          attention_hold_next = data;
        end else if (body_index == esp_pkg::MED_MARK_IDX && data != esp_pkg::MED_MARK_BYTE) begin
          markers_ok_next = 1'b0;
        end else if (body_index == esp_pkg::MED_IDX) begin
          meditation_hold_next = data;
        end
        if (body_index >= esp_pkg::LARGE_LAST) begin
          emit              = 1'b1;
          result.kind       = markers_ok ? esp_pkg::KIND_LARGE_OK : esp_pkg::KIND_LARGE_FAIL;
          result.attention  = markers_ok ? attention_hold : 8'd0;
          result.meditation = markers_ok ? meditation_hold : 8'd0;
          state_next        = esp_pkg::ST_HUNT;
          body_index_next   = '0;
          markers_ok_next   = 1'b1;
        end else begin
          body_index_next = body_index + 6'd1;
        end
      end
      default: begin
        state_next = fallback;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= esp_pkg::ST_HUNT;
      body_index <= '0;
      markers_ok <= 1'b1;
    end else if (step) begin
      state      <= state_next;
      body_index <= body_index_next;
      markers_ok <= markers_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sample_high     <= sample_high_next;
      sample_low      <= sample_low_next;
      attention_hold  <= attention_hold_next;
      meditation_hold <= meditation_hold_next;
    end
  end

  `ESP_CHECK(a_large_index, clk, rst, state != esp_pkg::ST_LBODY ||
    (body_index >= esp_pkg::LARGE_FIRST && body_index <= esp_pkg::LARGE_LAST))
  `ESP_CHECK(a_raw_index, clk, rst, state != esp_pkg::ST_RBODY ||
    (body_index >= esp_pkg::RAW_HIGH_IDX && body_index <= esp_pkg::RAW_CHK_IDX))
  `ESP_CHECK_NEXT(a_end_hunts, clk, rst, emit && step,
    state == esp_pkg::ST_HUNT && body_index == '0)

endmodule

FILE: rtl/core/esp_result_reg.sv
// Output register holding one decoded packet result until it is taken.
module esp_result_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  esp_pkg::esp_result_t load_data,
  input  logic                 take,
  output logic                 valid,
  output esp_pkg::esp_result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

FILE: rtl/core/eeg_serial_packet_parser.sv
// Top level of the EEG serial packet parser: input register, decoder and result register.
//
// The parser takes one word, a byte of the headset serial stream, per cycle unless its input
// stalls, and reports one result when the last byte of a packet has been seen: a raw sample
// (AA AA 04 80 02 hi lo chk) with its checksum status, or a large packet (AA AA 20 02 and 32
// body bytes) with attention and meditation or a format error. Each word is captured in an
// input register; from there the header state machine decodes it and writes any result into
// the output register. A new word is accepted every cycle unless the input stalls; the byte that
// ends a packet passes the input register and its result the output register. Input stalls only
// when a packet-ending byte waits in the input register while the previous result is untaken.
`include "eeg_serial_packet_parser_assert.svh"
module eeg_serial_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  packet_kind,
  output logic [15:0] sample_value,
  output logic [7:0]  attention,
  output logic [7:0]  meditation
);

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_fire;
  logic       emit;
  logic       result_load;

  esp_pkg::esp_result_t decoded;
  esp_pkg::esp_result_t held;

  // A byte may move through the decoder unless it ends a packet while the
  // result register is still occupied and not being drained this cycle.
  assign s1_fire    = s1_valid && (!emit || !result_valid || result_ready);
  assign byte_ready = !s1_valid || s1_fire;

  // The result register is written only when the packet's last byte really moves.
  assign result_load = emit && s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_byte <= stream_byte;
    end
  end

  esp_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_fire),
    .data   (s1_byte),
    .emit   (emit),
    .result (decoded)
  );

  esp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (result_load),
    .load_data (decoded),
    .take      (result_ready),
    .valid     (result_valid),
    .data      (held)
  );

  assign packet_kind  = held.kind;
  assign sample_value = held.sample;
  assign attention    = held.attention;
  assign meditation   = held.meditation;

  // A finished packet always lands in the result register.
  `ESP_CHECK_NEXT(a_emit_lands, clk, rst, result_load, result_valid)
  // The input side blocks only behind a packet end that cannot be delivered.
  `ESP_CHECK(a_ready_reason, clk, rst, byte_ready || (s1_valid && result_valid && !result_ready))
  // A byte held back in the input register is kept intact.
  `ESP_CHECK_NEXT(a_hold_byte, clk, rst, s1_valid && !s1_fire, s1_valid && $stable(s1_byte))

endmodule

FILE: sim/eeg_packet_checker.sv
// Checker for the EEG serial packet parser: predicts packet results from accepted words and compares.
module eeg_packet_checker
  import esp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  stream_byte,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [1:0]  packet_kind,
  input  logic [15:0] sample_value,
  input  logic [7:0]  attention,
  input  logic [7:0]  meditation,
  output int          mismatch_count,
  output int          packets_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Private copy of the parser state.
  esp_state_t  phase;
  esp_index_t  offset;
  logic [7:0]  high_hold;
  logic [7:0]  low_hold;
  logic [7:0]  att_hold;
  logic [7:0]  med_hold;
  logic        markers_good;

  esp_result_t expected_packets[$];
  esp_result_t oldest;

  // A broken header restarts on an AA, otherwise it goes back to hunting.
  task automatic fall_back(input logic [7:0] b);
    phase = (b == SYNC_BYTE) ? ST_AA1 : ST_HUNT;
  endtask

  task automatic parse_stream_byte(input logic [7:0] b);
    esp_result_t res;
    logic        emit;
    logic [7:0]  sum8;
    logic [7:0]  chk;
    res  = '0;
    emit = 1'b0;
    case (phase)
      ST_AA1: phase = (b == SYNC_BYTE) ? ST_AA2 : ST_HUNT;
      ST_AA2: begin
        if (b == RAW_LEN_BYTE) phase = ST_R04;
        else if (b == LARGE_LEN_BYTE) phase = ST_L20;
        else if (b == SYNC_BYTE) phase = ST_AA2;
        else phase = ST_HUNT;
      end
      ST_R04: begin
        if (b == RAW_CODE_BYTE) phase = ST_R80;
        else fall_back(b);
      end
      ST_R80: begin
        if (b == RAW_SIZE_BYTE) begin
          phase  = ST_RBODY;
          offset = RAW_HIGH_IDX;
        end else begin
          fall_back(b);
        end
      end
      ST_L20: begin
        if (b == LARGE_CODE) begin
          phase        = ST_LBODY;
          offset       = LARGE_FIRST;
          markers_good = 1'b1;
        end else begin
          fall_back(b);
        end
      end
      ST_RBODY: begin
        if (offset == RAW_HIGH_IDX) begin
          high_hold = b;
          offset    = RAW_LOW_IDX;
        end else if (offset == RAW_LOW_IDX) begin
          low_hold = b;
          offset   = RAW_CHK_IDX;
        end else begin
          sum8 = RAW_CODE_BYTE + RAW_SIZE_BYTE + high_hold + low_hold;
          chk  = ~sum8;
          if (chk == b) begin
            res.kind   = KIND_RAW_OK;
            res.sample = {high_hold, low_hold};
          end else begin
            res.kind = KIND_RAW_FAIL;
          end
          emit   = 1'b1;
          phase  = ST_HUNT;
          offset = '0;
        end
      end
      ST_LBODY: begin
        if (offset == ATT_MARK_IDX && b != ATT_MARK_BYTE) markers_good = 1'b0;
        else if (offset == ATT_IDX) att_hold = b;
        else if (offset == MED_MARK_IDX && b != MED_MARK_BYTE) markers_good = 1'b0;
        else if (offset == MED_IDX) med_hold = b;
        if (offset >= LARGE_LAST) begin
          if (markers_good) begin
            res.kind       = KIND_LARGE_OK;
            res.attention  = att_hold;
            res.meditation = med_hold;
          end else begin
            res.kind = KIND_LARGE_FAIL;
          end
          emit         = 1'b1;
          phase        = ST_HUNT;
          offset       = '0;
          markers_good = 1'b1;
        end else begin
          offset = offset + 6'd1;
        end
      end
      default: phase = (b == SYNC_BYTE) ? ST_AA1 : ST_HUNT;
    endcase
    if (emit) expected_packets = {expected_packets, res};
  endtask

  task automatic check_field(input string label, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase        = ST_HUNT;
      offset       = '0;
      high_hold    = '0;
      low_hold     = '0;
      att_hold     = '0;
      med_hold     = '0;
      markers_good = 1'b1;
      expected_packets.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_packets.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d", $time, packet_kind);
          mismatch_count++;
        end else begin
          oldest = expected_packets.pop_front();
          check_field("packet_kind", oldest.kind, packet_kind);
          check_field("sample_value", oldest.sample, sample_value);
          check_field("attention", oldest.attention, attention);
          check_field("meditation", oldest.meditation, meditation);
        end
      end
      if (byte_valid && byte_ready) parse_stream_byte(stream_byte);
    end
    packets_owed = expected_packets.size();
  end

endmodule

FILE: sim/eeg_serial_packet_parser_tb.sv
// Testbench top for the EEG serial packet parser: stimulus, flow control and verdict.
module eeg_serial_packet_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esp_pkg::*;

  // Number of stream words to offer in total, directed part included.
  localparam int ITEM_TARGET  = 1650;
  // Length of the long receiver hold-off that forces the parser to stall its input.
  localparam int STALL_CYCLES = 400;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic        byte_ready;
  logic [7:0]  stream_byte  = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  packet_kind;
  logic [15:0] sample_value;
  logic [7:0]  attention;
  logic [7:0]  meditation;

  int mismatch_count;
  int packets_owed;

  // Idle rates in percent; the stimulus changes them from phase to phase.
  int send_idle_pct      = 0;
  int recv_idle_pct      = 0;
  // Set once by the stimulus; the receiver process counts it down.
  int stall_cycles_left  = 0;
  int bytes_sent         = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  eeg_serial_packet_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .stream_byte  (stream_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .packet_kind  (packet_kind),
    .sample_value (sample_value),
    .attention    (attention),
    .meditation   (meditation)
  );

  eeg_packet_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .stream_byte    (stream_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .packet_kind    (packet_kind),
    .sample_value   (sample_value),
    .attention      (attention),
    .meditation     (meditation),
    .mismatch_count (mismatch_count),
    .packets_owed   (packets_owed)
  );

  // Offers one word. Any idle cycles come first, then valid rises with the word and stays up
  // until the parser takes it. The task returns on the falling edge after the handshake, so
  // the next call makes the only assignment to byte_valid at that edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid  <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Raw sample packet: AA AA 04 80 02 hi lo chk. With good_chk clear the checksum byte is
  // damaged by a nonzero mask, so the packet must come back as a checksum failure.
  task automatic send_raw_packet(input logic [7:0] hi, input logic [7:0] lo,
                                 input logic good_chk);
    logic [7:0] sum8;
    logic [7:0] chk;
    sum8 = RAW_CODE_BYTE + RAW_SIZE_BYTE + hi + lo;
    chk  = ~sum8;
    if (!good_chk) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(RAW_LEN_BYTE);
    send_byte(RAW_CODE_BYTE);
    send_byte(RAW_SIZE_BYTE);
    send_byte(hi);
    send_byte(lo);
    send_byte(chk);
  endtask

  // Large packet: AA AA 20 02 and 32 body words at offsets 4 to 35. The filler words are
  // often sync bytes, since the parser must never hunt for a header inside a body.
  task automatic send_large_packet(input logic [7:0] att, input logic [7:0] med,
                                   input logic [7:0] att_mark, input logic [7:0] med_mark);
    logic [7:0] b;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(LARGE_LEN_BYTE);
    send_byte(LARGE_CODE);
    for (int off = LARGE_FIRST; off <= LARGE_LAST; off++) begin
      if (off == ATT_MARK_IDX) b = att_mark;
      else if (off == ATT_IDX) b = att;
      else if (off == MED_MARK_IDX) b = med_mark;
      else if (off == MED_IDX) b = med;
      else if ($urandom_range(3) == 0) b = SYNC_BYTE;
      else b = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  // Marker word for a large packet: mostly the right one, sometimes anything at all.
  function automatic logic [7:0] pick_marker(input logic [7:0] good);
    return ($urandom_range(9) < 7) ? good : 8'($urandom_range(255));
  endfunction

  // One random chunk of stream: mostly well-formed packets with random content, the rest
  // headers cut short and plain noise.
  task automatic send_random_chunk();
    logic [7:0] raw_head[5];
    logic [7:0] large_head[4];
    int         pick;
    int         cut;
    raw_head   = '{SYNC_BYTE, SYNC_BYTE, RAW_LEN_BYTE, RAW_CODE_BYTE, RAW_SIZE_BYTE};
    large_head = '{SYNC_BYTE, SYNC_BYTE, LARGE_LEN_BYTE, LARGE_CODE};
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_raw_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                      $urandom_range(3) != 0);
    end else if (pick < 65) begin
      send_large_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                        pick_marker(ATT_MARK_BYTE), pick_marker(MED_MARK_BYTE));
    end else if (pick < 85) begin
      // A header sent up to a random length, full length included, then a random word that is
      // often a sync byte so that the fall back to the one-AA phase gets exercised.
      if ($urandom_range(1) == 0) begin
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++) send_byte(raw_head[i]);
      end else begin
        cut = $urandom_range(1, 4);
        for (int i = 0; i < cut; i++) send_byte(large_head[i]);
      end
      send_byte(($urandom_range(2) == 0) ? SYNC_BYTE : 8'($urandom_range(255)));
    end else begin
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut; i++)
        send_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom_range(255)));
    end
  endtask

  // Receiver: random ready at the chosen rate, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ready <= 1'b0;
      end else if (stall_cycles_left > 0) begin
        result_ready <= 1'b0;
        stall_cycles_left--;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First phase: the sender idles 30 percent of the time, the receiver 81 percent.
    send_idle_pct = 30;
    recv_idle_pct = 81;

    // Directed part. Raw packets at the extremes of the sample, one with a bad checksum.
    send_raw_packet(8'h00, 8'h00, 1'b1);
    send_raw_packet(8'hFF, 8'hFF, 1'b1);
    send_raw_packet(8'h5A, 8'hA5, 1'b0);
    // Repeated sync bytes keep the two-AA phase.
    send_byte(SYNC_BYTE);
    send_raw_packet(8'h80, 8'h01, 1'b1);
    // Broken raw header on a sync byte, then the rest of a packet from there.
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(RAW_LEN_BYTE);
    send_raw_packet(8'h12, 8'h34, 1'b1);
    // Unknown length byte after the sync pair goes back to hunting.
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h33);
    // Broken large header on a plain byte.
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(LARGE_LEN_BYTE);
    send_byte(8'h00);
    // Large packets: good, then each marker wrong in turn.
    send_large_packet(8'hFF, 8'h00, ATT_MARK_BYTE, MED_MARK_BYTE);
    send_large_packet(8'h00, 8'hFF, 8'h05, MED_MARK_BYTE);
    send_large_packet(8'h11, 8'h22, ATT_MARK_BYTE, 8'h04);

    // Random part, first phase.
    while (bytes_sent < ITEM_TARGET / 3) send_random_chunk();

    // Second phase: the rates swap.
    send_idle_pct = 81;
    recv_idle_pct = 30;
    while (bytes_sent < 2 * ITEM_TARGET / 3) send_random_chunk();

    // Third phase: nobody idles. It opens with a long receiver hold-off while raw packets
    // keep coming, so the parser fills up and has to drop byte_ready.
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    stall_cycles_left = STALL_CYCLES;
    repeat (12) send_raw_packet(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    while (bytes_sent < ITEM_TARGET) send_random_chunk();
    byte_valid <= 1'b0;

    // Drain: every predicted result must come back, then stray results get time to show up.
    while (packets_owed != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/esp_pkg.sv
rtl/core/esp_fsm.sv
rtl/core/esp_result_reg.sv
rtl/core/eeg_serial_packet_parser.sv
sim/eeg_packet_checker.sv
sim/eeg_serial_packet_parser_tb.sv
